@@ src/pwm_command_parser_top_defines.svh @@
// assertion macros for the pwm command parser
// used by pwm_command_parser_top; needs clk and rst_n in the using scope
`ifndef PWM_COMMAND_PARSER_TOP_DEFINES_SVH
`define PWM_COMMAND_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define PCP_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcp same-cycle check failed");

// next-cycle implication, checked out of reset
`define PCP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcp next-cycle check failed");

`else

`define PCP_ASSERT_SAME(name, ante, cons)
`define PCP_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ src/pcp_pkg.sv @@
// shared types, codes and character constants for the pwm command parser
// no dependencies
package pcp_pkg;

    // item moved on the command channel
    typedef struct packed {
        logic [7:0] ch;
        logic       end_mark;
    } cmd_item_t;

    // item moved on the response channel
    typedef struct packed {
        logic [1:0] result_code;
        logic       enabled;
        logic [6:0] duty_level;
        logic [6:0] drive_level;
    } rsp_item_t;

    // per-cycle control from the top level to the parser
    typedef struct packed {
        logic take_char;
        logic finish;
    } pcp_step_t;

    // result codes
    localparam logic [1:0] RC_CHANGED = 2'd0;
    localparam logic [1:0] RC_STATUS  = 2'd1;
    localparam logic [1:0] RC_BAD     = 2'd2;

    localparam int         ACC_W      = 10;
    localparam logic [6:0] DUTY_RESET = 7'd50;
    localparam logic [6:0] DUTY_MAX   = 7'd100;
    localparam logic [3:0] POS_MAX    = 4'd15;

    localparam logic [3:0] LEN_ON     = 4'd2;
    localparam logic [3:0] LEN_OFF    = 4'd3;
    localparam logic [3:0] LEN_STATUS = 4'd6;
    localparam logic [3:0] LEN_PWM    = 4'd4;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    // "ON" by position
    function automatic logic [7:0] on_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h4F;
            4'd1:    c = 8'h4E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "OFF" by position
    function automatic logic [7:0] off_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h4F;
            4'd1:    c = 8'h46;
            4'd2:    c = 8'h46;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Status" by position
    function automatic logic [7:0] status_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h53;
            4'd1:    c = 8'h74;
            4'd2:    c = 8'h61;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h75;
            4'd5:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "PWM:" by position
    function automatic logic [7:0] pwm_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h50;
            4'd1:    c = 8'h57;
            4'd2:    c = 8'h4D;
            4'd3:    c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ src/pcp_parser.sv @@
// parse state, enable flag and duty store of the pwm command parser
// depends on pcp_pkg
module pcp_parser
    import pcp_pkg::*;
#(
    parameter int MAX_DIGITS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  pcp_step_t  step,
    input  logic [7:0] ch,
    output rsp_item_t  result
);

    localparam int DCW = $clog2(MAX_DIGITS + 1);
    localparam logic [DCW-1:0] DIGIT_LIMIT = DCW'(MAX_DIGITS);

    logic [3:0]       pos_reg, pos_next;
    logic [2:0]       word_reg, word_next;
    logic             prefix_reg, prefix_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [DCW-1:0]   dcnt_reg, dcnt_next;
    logic             pct_reg, pct_next;
    logic             rej_reg, rej_next;
    logic             en_reg, en_next;
    logic [6:0]       duty_reg, duty_next;

    logic             is_digit;
    logic [ACC_W-1:0] acc_times_ten;
    logic [1:0]       code;
    logic             fin_en;
    logic [6:0]       fin_duty;

    assign is_digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1);

    // end-of-command decision
    always_comb
    begin
        code     = RC_BAD;
        fin_en   = en_reg;
        fin_duty = duty_reg;
        priority if (word_reg[0] && pos_reg == LEN_ON)
        begin
            fin_en = 1'b1;
            code   = RC_CHANGED;
        end
        else if (word_reg[1] && pos_reg == LEN_OFF)
        begin
            fin_en = 1'b0;
            code   = RC_CHANGED;
        end
        else if (word_reg[2] && pos_reg == LEN_STATUS)
        begin
            code = RC_STATUS;
        end
        else if (prefix_reg && pos_reg >= LEN_PWM && !rej_reg && dcnt_reg != '0
                 && pct_reg && acc_reg <= ACC_W'(DUTY_MAX))
        begin
            fin_duty = acc_reg[6:0];
            code     = RC_CHANGED;
        end
        else
        begin
            code = RC_BAD;
        end
    end

    // result item, meaningful when finish is set
    always_comb
    begin
        result.result_code = code;
        result.enabled     = fin_en;
        result.duty_level  = fin_duty;
        result.drive_level = fin_en ? fin_duty : 7'd0;
    end

    // per-character update and clear at end of command
    always_comb
    begin
        pos_next    = pos_reg;
        word_next   = word_reg;
        prefix_next = prefix_reg;
        acc_next    = acc_reg;
        dcnt_next   = dcnt_reg;
        pct_next    = pct_reg;
        rej_next    = rej_reg;
        en_next     = en_reg;
        duty_next   = duty_reg;
        if (step.finish)
        begin
            en_next     = fin_en;
            duty_next   = fin_duty;
            pos_next    = '0;
            word_next   = 3'b111;
            prefix_next = 1'b1;
            acc_next    = '0;
            dcnt_next   = '0;
            pct_next    = 1'b0;
            rej_next    = 1'b0;
        end
        else if (step.take_char)
        begin
            word_next[0] = word_reg[0] && (pos_reg < LEN_ON) && (on_char(pos_reg) == ch);
            word_next[1] = word_reg[1] && (pos_reg < LEN_OFF) && (off_char(pos_reg) == ch);
            word_next[2] = word_reg[2] && (pos_reg < LEN_STATUS)
                           && (status_char(pos_reg) == ch);
            if (prefix_reg)
            begin
                if (pos_reg < LEN_PWM)
                begin
                    if (pwm_char(pos_reg) != ch)
                        prefix_next = 1'b0;
                end
                else if (!rej_reg)
                begin
                    priority if (pct_reg)
                        rej_next = 1'b1;
                    else if (is_digit)
                    begin
                        if (dcnt_reg >= DIGIT_LIMIT)
                            rej_next = 1'b1;
                        else
                        begin
                            dcnt_next = dcnt_reg + 1'b1;
                            acc_next  = acc_times_ten + ACC_W'(ch - CH_ZERO);
                        end
                    end
                    else if (ch == CH_PERCENT && dcnt_reg != '0)
                        pct_next = 1'b1;
                    else
                        rej_next = 1'b1;
                end
            end
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 4'd1;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            word_reg   <= 3'b111;
            prefix_reg <= 1'b1;
            acc_reg    <= '0;
            dcnt_reg   <= '0;
            pct_reg    <= 1'b0;
            rej_reg    <= 1'b0;
            en_reg     <= 1'b0;
            duty_reg   <= DUTY_RESET;
        end
        else
        begin
            pos_reg    <= pos_next;
            word_reg   <= word_next;
            prefix_reg <= prefix_next;
            acc_reg    <= acc_next;
            dcnt_reg   <= dcnt_next;
            pct_reg    <= pct_next;
            rej_reg    <= rej_next;
            en_reg     <= en_next;
            duty_reg   <= duty_next;
        end
    end

endmodule

@@ src/pcp_out_stage.sv @@
// response register of the pwm command parser, holds an item until taken
// depends on pcp_pkg
module pcp_out_stage
    import pcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  rsp_item_t rsp_in,
    input  logic      rsp_stall,
    output logic      rsp_valid,
    output rsp_item_t rsp
);

    logic      vld_reg, vld_next;
    rsp_item_t rsp_reg, rsp_next;

    // valid: set on load, cleared once taken
    always_comb
    begin
        vld_next = vld_reg;
        rsp_next = rsp_reg;
        if (load)
        begin
            vld_next = 1'b1;
            rsp_next = rsp_in;
        end
        else if (!rsp_stall)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = vld_reg;
    assign rsp       = rsp_reg;

endmodule

@@ src/pwm_command_parser_top.sv @@
// top level of the pwm command parser: input register, parser, response register
// depends on pcp_pkg, pcp_parser, pcp_out_stage, pwm_command_parser_top_defines.svh
//
//   channel   handshake                payload     role
//   cmd       cmd_valid / cmd_stall    cmd_item_t  one character or end marker
//   rsp       rsp_valid / rsp_stall    rsp_item_t  one result per end marker
//
// one item per cycle sustained while no end marker is held back; a character
// is registered, then folded into the parse state at the next edge; an end
// marker's result is loaded into the response register when the marker leaves
// the input register, and is valid from then on. the only back-pressure is an
// end marker waiting on a full, stalled response register. reset is asynchronous,
// active low, and returns enable off, duty 50 and an empty command.
`include "pwm_command_parser_top_defines.svh"

module pwm_command_parser_top
    import pcp_pkg::*;
#(
    parameter int MAX_DIGITS = 3
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    logic      cmd_vld_reg, cmd_vld_next;
    cmd_item_t cmd_reg, cmd_next;
    logic      out_free;
    logic      consume;
    logic      accept;
    pcp_step_t step;
    rsp_item_t result;
    logic [6:0] drive_want;

    // handshake control
    assign out_free  = !rsp_valid || !rsp_stall;
    assign cmd_stall = cmd_vld_reg && cmd_reg.end_mark && !out_free;
    assign consume   = cmd_vld_reg && !cmd_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign step.take_char = consume && !cmd_reg.end_mark;
    assign step.finish    = consume && cmd_reg.end_mark;

    // input register
    always_comb
    begin
        cmd_vld_next = cmd_vld_reg;
        cmd_next     = cmd_reg;
        if (accept)
        begin
            cmd_vld_next = 1'b1;
            cmd_next     = cmd;
        end
        else if (consume)
            cmd_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_vld_reg <= 1'b0;
        else
            cmd_vld_reg <= cmd_vld_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // parser
    pcp_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .ch     (cmd_reg.ch),
        .result (result)
    );

    // response register
    pcp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step.finish),
        .rsp_in    (result),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // expected output level of the item on offer
    assign drive_want = rsp.enabled ? rsp.duty_level : 7'd0;

    // checks
    `PCP_ASSERT_NEXT(a_finish_gives_rsp, step.finish, rsp_valid)
    `PCP_ASSERT_SAME(a_drive_matches, rsp_valid, rsp.drive_level == drive_want)
    `PCP_ASSERT_SAME(a_duty_in_range, rsp_valid, rsp.duty_level <= DUTY_MAX)

endmodule
